@@ design/mlbc_pkg.sv @@
`default_nettype none
package mlbc_pkg;

    localparam int LED_COUNT = 8;
    localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam int KIND_W = 3;
    localparam int HP_W   = 16;
    localparam int DUR_W  = 24;
    localparam int MASK_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 3'd0,
        KIND_ON        = 3'd1,
        KIND_OFF       = 3'd2,
        KIND_BLINK     = 3'd3,
        KIND_BLINK_DUR = 3'd4,
        KIND_STOP      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DONE
    } state_t;

    // Everything kept for one LED.
    typedef struct packed {
        logic            lit;
        logic            blinking;
        logic            stop_pending;
        logic [HP_W-1:0] half_period;
        logic [HP_W-1:0] elapsed;
        logic [DUR_W-1:0] remaining;
    } led_state_t;

endpackage
`default_nettype wire

@@ design/mlbc_tick_unit.sv @@
`default_nettype none
// Advance one LED by one 1 ms tick.
module mlbc_tick_unit (
    input  wire mlbc_pkg::led_state_t cur,
    output mlbc_pkg::led_state_t      nxt
);

    logic [mlbc_pkg::DUR_W-1:0] rem_dec;
    logic [mlbc_pkg::HP_W:0]    el_inc;

    assign rem_dec = cur.remaining - mlbc_pkg::DUR_W'(1);
    assign el_inc  = {1'b0, cur.elapsed} + (mlbc_pkg::HP_W + 1)'(1);

    always_comb begin
        nxt = cur;
        if (cur.stop_pending) begin
            // Drop the pending stop and force the pin off; skip blinking.
            nxt.stop_pending = 1'b0;
            nxt.lit          = 1'b0;
        end else if (cur.blinking) begin
            if (cur.remaining != '0 && rem_dec == '0) begin
                // Lifetime over: end blinking.
                nxt.remaining = rem_dec;
                nxt.blinking  = 1'b0;
                nxt.elapsed   = '0;
                nxt.lit       = 1'b0;
            end else begin
                if (cur.remaining != '0) begin
                    nxt.remaining = rem_dec;
                end
                if (el_inc >= {1'b0, cur.half_period}) begin
                    nxt.elapsed = '0;
                    nxt.lit     = ~cur.lit;
                end else begin
                    nxt.elapsed = el_inc[mlbc_pkg::HP_W-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ design/multi_led_blink_controller.sv @@
`default_nettype none
// A command transaction updates the addressed LED in S_IDLE and then publishes the mask
// from S_DONE; a tick transaction first walks every LED in S_TICK. A new transaction
// is accepted only in S_IDLE, after the previous result has been published; the tick
// walks the LEDs one per cycle through a single shared per-LED update unit. S_DONE
// waits while the previous result sits in the output register untaken.
// Reset (aresetn, synchronous, active low): all LEDs off, no blinking, no pending
// stops, sequencer idle, no result pending.
module multi_led_blink_controller (
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [2:0] s_kind,
    input  wire  [2:0] s_led_index,
    input  wire [15:0] s_half_period_ms,
    input  wire [23:0] s_duration_ms,

    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_led_mask
);

    localparam int N  = mlbc_pkg::LED_COUNT;
    localparam int IW = mlbc_pkg::LED_IDX_W;

    // Sequencer state, tick counter and output register.
    mlbc_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_mask_reg, m_mask_next;

    // Per-LED state: pin, blink and stop flags as vectors, counters as arrays.
    logic [N-1:0]               lit_reg, blink_reg, stop_reg;
    logic [mlbc_pkg::HP_W-1:0]  hp_reg  [N];
    logic [mlbc_pkg::HP_W-1:0]  el_reg  [N];
    logic [mlbc_pkg::DUR_W-1:0] rem_reg [N];

    logic                 accept;
    logic [IW-1:0]        cmd_idx;
    logic                 idx_ok;
    logic [IW-1:0]        rd_idx;
    mlbc_pkg::led_state_t cur_led, tick_led, cmd_led, wr_led;
    logic                 wr_en;
    logic                 cnt_last;
    logic [7:0]           lit_mask;

    assign s_ready    = (state_reg == mlbc_pkg::S_IDLE);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_led_mask = m_mask_reg;

    assign cmd_idx  = IW'(s_led_index);
    assign idx_ok   = 32'(s_led_index) < N;
    assign cnt_last = (cnt_reg == IW'(N - 1));

    // One read/write port into the LED state: tick counter while ticking,
    // command index otherwise.
    assign rd_idx = (state_reg == mlbc_pkg::S_TICK) ? cnt_reg : cmd_idx;

    always_comb begin
        cur_led.lit          = lit_reg[rd_idx];
        cur_led.blinking     = blink_reg[rd_idx];
        cur_led.stop_pending = stop_reg[rd_idx];
        cur_led.half_period  = hp_reg[rd_idx];
        cur_led.elapsed      = el_reg[rd_idx];
        cur_led.remaining    = rem_reg[rd_idx];
    end

    mlbc_tick_unit u_tick (
        .cur (cur_led),
        .nxt (tick_led)
    );

    // Apply a command to the addressed LED.
    always_comb begin
        cmd_led = cur_led;
        case (s_kind)
            mlbc_pkg::KIND_ON: begin
                cmd_led.lit = 1'b1;
            end
            mlbc_pkg::KIND_OFF: begin
                cmd_led.lit = 1'b0;
            end
            mlbc_pkg::KIND_BLINK, mlbc_pkg::KIND_BLINK_DUR: begin
                cmd_led.elapsed     = '0;
                cmd_led.blinking    = 1'b1;
                cmd_led.half_period = s_half_period_ms;
                cmd_led.remaining   = (s_kind == mlbc_pkg::KIND_BLINK_DUR) ?
                                      s_duration_ms : '0;
            end
            mlbc_pkg::KIND_STOP: begin
                // Stop takes effect now; the pending flag forces off at next tick.
                cmd_led.blinking     = 1'b0;
                cmd_led.elapsed      = '0;
                cmd_led.stop_pending = 1'b1;
                cmd_led.lit          = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Pin mask: LEDs beyond bit 7 are never reported.
    always_comb begin
        lit_mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < N) begin
                lit_mask[i] = lit_reg[i];
            end
        end
    end

    // Sequencer: next state, write enable and output register.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_mask_next  = m_mask_reg;
        wr_en        = 1'b0;
        wr_led       = cmd_led;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mlbc_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_kind == mlbc_pkg::KIND_TICK) begin
                        cnt_next   = '0;
                        state_next = mlbc_pkg::S_TICK;
                    end else begin
                        // Unknown kinds and out-of-range LEDs leave the state alone.
                        wr_en      = idx_ok && (s_kind <= mlbc_pkg::KIND_STOP);
                        state_next = mlbc_pkg::S_DONE;
                    end
                end
            end
            mlbc_pkg::S_TICK: begin
                // Advance one LED per cycle through the shared update unit.
                wr_en  = 1'b1;
                wr_led = tick_led;
                if (cnt_last) begin
                    state_next = mlbc_pkg::S_DONE;
                end else begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            mlbc_pkg::S_DONE: begin
                // Hold until the output register is free, then publish the mask.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mask_next  = lit_mask;
                    state_next   = mlbc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mlbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mlbc_pkg::S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            lit_reg     <= '0;
            blink_reg   <= '0;
            stop_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (wr_en) begin
                lit_reg[rd_idx]   <= wr_led.lit;
                blink_reg[rd_idx] <= wr_led.blinking;
                stop_reg[rd_idx]  <= wr_led.stop_pending;
            end
        end
    end

    // Counters are only read while blinking, which is set together with them.
    always_ff @(posedge aclk) begin
        m_mask_reg <= m_mask_next;
        if (wr_en) begin
            hp_reg[rd_idx]  <= wr_led.half_period;
            el_reg[rd_idx]  <= wr_led.elapsed;
            rem_reg[rd_idx] <= wr_led.remaining;
        end
    end

`ifndef SYNTH
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlbc_pkg::S_TICK && !cnt_last) |=>
            (state_reg == mlbc_pkg::S_TICK && cnt_reg == $past(cnt_reg) + IW'(1)))
        else $error("tick counter did not advance");

    a_stops_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlbc_pkg::S_TICK && cnt_last) |=> (stop_reg == '0))
        else $error("pending stop survived a tick");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == mlbc_pkg::S_DONE))
        else $error("result published outside done state");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlbc_pkg::S_TICK) |-> !wr_en || (rd_idx == cnt_reg))
        else $error("tick write off the counter");
`endif

endmodule
`default_nettype wire
